// ----- rtl/core/pbb_pkg.sv -----
// Shared types and constants for the locus pileup bucket builder.
// No dependencies.
package pbb_pkg;

  localparam int unsigned DefLoci    = 1024;
  localparam int unsigned DefEntries = 4096;
  localparam int unsigned DefReads   = 4096;

  typedef enum logic [1:0] {
    ACT_ENTRY    = 2'd0,
    ACT_END_READ = 2'd1,
    ACT_FINALIZE = 2'd2,
    ACT_QUERY    = 2'd3
  } pbb_action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LOCUS_RNG = 3'd1,
    ST_BUF_FULL  = 3'd2,
    ST_READ_OVF  = 3'd3,
    ST_BAD_RANK  = 3'd4,
    ST_NOT_BUILT = 3'd5
  } pbb_status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_EWR,
    S_PRD,
    S_PWR,
    S_SRD1,
    S_SRD2,
    S_SWR,
    S_QRD,
    S_QOUT
  } pbb_state_t;

endpackage

// ----- rtl/core/pbb_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module pbb_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/locus_pileup_bucket_builder_top.sv -----
// Locus pileup bucket builder: counting-sort CSR index from reads to loci.
// Uses pbb_pkg and pbb_ram.
//
// One word in, one word out per item. An entry writes the buffer, then updates its count;
// an end-of-read word is answered at once. A query reads the count, then the pileup RAM,
// unless the rank is beyond the count. A word rejected at its first check (locus range,
// read overflow, buffer full, not built) is answered without leaving the idle state.
// The count, offset and pileup RAMs have registered read ports. Finalize makes a
// prefix-sum pass over the loci, then scatters each buffered entry through the
// offset/fill RAM. After reset a clearing pass zeroes every count in the count
// RAM before the first word is taken. A new load after a build clears the
// counts at once by flipping an epoch bit kept with each count.
module locus_pileup_bucket_builder_top
  import pbb_pkg::*;
#(
  parameter int unsigned LOCI    = DefLoci,
  parameter int unsigned ENTRIES = DefEntries,
  parameter int unsigned READS   = DefReads
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [9:0]  locus,
  input  logic [11:0] rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] read_number,
  output logic [12:0] bucket_count,
  output logic [10:0] locus_span
);

  localparam int unsigned LW = $clog2(LOCI);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = $clog2(READS + 1);
  localparam int unsigned SW = $clog2(LOCI + 1);
  localparam int unsigned PW = ((CW > 12) ? CW : 12) + 1;

  pbb_state_t state, state_next;

  logic [LW-1:0] idx;
  logic [CW-1:0] eidx;
  logic [CW-1:0] run;
  logic          epoch;
  logic [RW-1:0] cur_read;
  logic [CW-1:0] held;
  logic [SW-1:0] span;
  logic          built;
  logic [LW-1:0] lat_loc;
  logic [RW-1:0] lat_read;
  logic [11:0]   lat_rank;
  logic [CW-1:0] q_count;
  logic          q_pos_ok;

  logic          cnt_we;
  logic [LW-1:0] cnt_waddr, cnt_raddr;
  logic [CW:0]   cnt_wdata, cnt_rdata;
  logic          off_we;
  logic [LW-1:0] off_waddr, off_raddr;
  logic [2*CW-1:0] off_wdata, off_rdata;
  logic          buf_we;
  logic [EW-1:0] buf_waddr, buf_raddr;
  logic [LW+RW-1:0] buf_wdata, buf_rdata;
  logic          pile_we;
  logic [EW-1:0] pile_waddr, pile_raddr;
  logic [RW-1:0] pile_wdata, pile_rdata;

  logic          accept;
  logic          clear_now;
  logic [LW-1:0] loc_a;
  logic          loc_bad;
  logic [RW-1:0] cr_eff;
  logic [CW-1:0] held_eff;
  logic [SW-1:0] span_eff;
  logic [SW-1:0] span_cand;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] off_o, off_f;
  logic [CW-1:0] scat_pos;
  logic [PW-1:0] q_pos;
  logic          scan_last;

  pbb_ram #(.W(CW + 1), .D(LOCI)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  pbb_ram #(.W(2 * CW), .D(LOCI)) u_off (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );
  pbb_ram #(.W(LW + RW), .D(ENTRIES)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );
  pbb_ram #(.W(RW), .D(ENTRIES)) u_pile (
    .clk(clk), .we(pile_we), .waddr(pile_waddr), .wdata(pile_wdata),
    .raddr(pile_raddr), .rdata(pile_rdata)
  );

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign loc_a     = LW'(locus);
  assign loc_bad   = {22'd0, locus} >= 32'(LOCI);
  assign clear_now = built && ((action == ACT_ENTRY) || (action == ACT_END_READ));
  assign cr_eff    = clear_now ? '0 : cur_read;
  assign held_eff  = clear_now ? '0 : held;
  assign span_eff  = clear_now ? '0 : span;
  assign span_cand = SW'(loc_a) + SW'(1);
  assign cnt_eff   = (cnt_rdata[CW] == epoch) ? cnt_rdata[CW-1:0] : '0;
  assign off_o     = off_rdata[2*CW-1:CW];
  assign off_f     = off_rdata[CW-1:0];
  assign scat_pos  = off_o + off_f;
  assign q_pos     = PW'(off_o) + PW'(lat_rank);
  assign scan_last = (eidx + CW'(1)) == held;

  always_comb begin
    state_next = state;
    cnt_we     = 1'b0;
    cnt_waddr  = idx;
    cnt_wdata  = {epoch, cnt_eff};
    cnt_raddr  = loc_a;
    off_we     = 1'b0;
    off_waddr  = idx;
    off_wdata  = {run, {CW{1'b0}}};
    off_raddr  = loc_a;
    buf_we     = 1'b0;
    buf_waddr  = held_eff[EW-1:0];
    buf_wdata  = {loc_a, cr_eff};
    buf_raddr  = eidx[EW-1:0];
    pile_we    = 1'b0;
    pile_waddr = scat_pos[EW-1:0];
    pile_wdata = lat_read;
    pile_raddr = q_pos[EW-1:0];
    unique case (state)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_wdata = '0;
        if (idx == LW'(LOCI - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (pbb_action_t'(action))
            ACT_ENTRY: begin
              if (!loc_bad && cr_eff < RW'(READS) && held_eff < CW'(ENTRIES)) begin
                buf_we     = 1'b1;
                state_next = S_EWR;
              end
            end
            ACT_END_READ: state_next = S_IDLE;
            ACT_FINALIZE: state_next = S_PRD;
            ACT_QUERY: begin
              if (built && !loc_bad) begin
                state_next = S_QRD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EWR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = lat_loc;
        cnt_wdata  = {epoch, cnt_eff + CW'(1)};
        state_next = S_IDLE;
      end
      S_PRD: begin
        cnt_raddr  = idx;
        state_next = S_PWR;
      end
      S_PWR: begin
        cnt_we = 1'b1;
        off_we = 1'b1;
        if (idx == LW'(LOCI - 1)) begin
          state_next = (held == '0) ? S_IDLE : S_SRD1;
        end else begin
          state_next = S_PRD;
        end
      end
      S_SRD1: state_next = S_SRD2;
      S_SRD2: begin
        off_raddr  = buf_rdata[LW+RW-1:RW];
        state_next = S_SWR;
      end
      S_SWR: begin
        off_we     = 1'b1;
        off_waddr  = lat_loc;
        off_wdata  = {off_o, off_f + CW'(1)};
        pile_we    = {1'b0, scat_pos} < (CW+1)'(ENTRIES);
        state_next = scan_last ? S_IDLE : S_SRD1;
      end
      S_QRD: begin
        state_next = (PW'(lat_rank) >= PW'(cnt_eff)) ? S_IDLE : S_QOUT;
      end
      S_QOUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      epoch     <= 1'b0;
      cur_read  <= '0;
      held      <= '0;
      span      <= '0;
      built     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: idx <= idx + LW'(1);
        S_IDLE: begin
          if (accept) begin
            lat_loc      <= loc_a;
            lat_rank     <= rank;
            idx          <= '0;
            run          <= '0;
            eidx         <= '0;
            read_number  <= '0;
            bucket_count <= '0;
            if (clear_now) begin
              epoch    <= ~epoch;
              cur_read <= '0;
              held     <= '0;
              span     <= '0;
              built    <= 1'b0;
            end
            unique case (pbb_action_t'(action))
              ACT_ENTRY: begin
                out_valid  <= 1'b1;
                locus_span <= 11'(span_eff);
                if (loc_bad) begin
                  status <= ST_LOCUS_RNG;
                end else if (cr_eff >= RW'(READS)) begin
                  status <= ST_READ_OVF;
                end else if (held_eff >= CW'(ENTRIES)) begin
                  status <= ST_BUF_FULL;
                end else begin
                  status <= ST_OK;
                  held   <= held_eff + CW'(1);
                  if (span_cand > span_eff) begin
                    span       <= span_cand;
                    locus_span <= 11'(span_cand);
                  end else begin
                    span <= span_eff;
                  end
                end
              end
              ACT_END_READ: begin
                out_valid  <= 1'b1;
                locus_span <= 11'(span_eff);
                if (cr_eff >= RW'(READS)) begin
                  status <= ST_READ_OVF;
                end else begin
                  status   <= ST_OK;
                  cur_read <= cr_eff + RW'(1);
                end
              end
              ACT_FINALIZE: ;
              ACT_QUERY: begin
                locus_span <= 11'(span);
                if (!built) begin
                  out_valid <= 1'b1;
                  status    <= ST_NOT_BUILT;
                end else if (loc_bad) begin
                  out_valid <= 1'b1;
                  status    <= ST_LOCUS_RNG;
                end
              end
              default: ;
            endcase
          end
        end
        S_EWR: ;
        S_PRD: ;
        S_PWR: begin
          run <= run + cnt_eff;
          idx <= idx + LW'(1);
          if (idx == LW'(LOCI - 1) && held == '0) begin
            built      <= 1'b1;
            out_valid  <= 1'b1;
            status     <= ST_OK;
            locus_span <= 11'(span);
          end
        end
        S_SRD1: ;
        S_SRD2: begin
          lat_loc  <= buf_rdata[LW+RW-1:RW];
          lat_read <= buf_rdata[RW-1:0];
        end
        S_SWR: begin
          eidx <= eidx + CW'(1);
          if (scan_last) begin
            built      <= 1'b1;
            out_valid  <= 1'b1;
            status     <= ST_OK;
            locus_span <= 11'(span);
          end
        end
        S_QRD: begin
          bucket_count <= 13'(cnt_eff);
          q_count      <= cnt_eff;
          q_pos_ok     <= q_pos < PW'(ENTRIES);
          if (PW'(lat_rank) >= PW'(cnt_eff)) begin
            out_valid <= 1'b1;
            status    <= ST_BAD_RANK;
          end
        end
        S_QOUT: begin
          out_valid   <= 1'b1;
          status      <= ST_OK;
          read_number <= q_pos_ok ? 12'(pile_rdata) : 12'd0;
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("ready outside idle");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(ENTRIES))
    else $error("entry count beyond buffer");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    cur_read <= RW'(READS))
    else $error("read number beyond limit");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWR && scan_last) |=> (built && out_valid && state == S_IDLE))
    else $error("scatter end did not finish build");

  a_count_small: assert property (@(posedge clk) disable iff (rst)
    (state == S_QOUT) |-> (q_count != '0))
    else $error("query hit empty bucket");

endmodule
